/* src/refcounted_resource_cache_macros.svh */
// Assertion macros shared by the cache RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef REFCOUNTED_RESOURCE_CACHE_MACROS_SVH
`define REFCOUNTED_RESOURCE_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rrc_pkg.sv */
// Types and constants of the reference-counted resource cache.
// No dependencies; used by the top level, its port list and the testbench.
`default_nettype none

package rrc_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int RES_ID_W        = 15;
    localparam int ID_W            = 16;
    localparam int SLOT_W8         = 8;
    localparam int CNT_W           = 8;
    localparam int WORD_W          = ID_W + CNT_W;

    localparam logic [ID_W-1:0]  EMPTY_ID  = 16'hFFFF;
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [RES_ID_W-1:0] res_id;
        logic [SLOT_W8-1:0]  slot_in;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W8-1:0] slot_out;
        logic               needs_load;
        logic [CNT_W-1:0]   use_count;
        logic               freed;
    } t_rsp;

endpackage

`default_nettype wire

/* src/rrc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rrc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/refcounted_resource_cache.sv */
// Top level of the reference-counted resource cache: sequencer and slot table.
// Depends on rrc_pkg, rrc_ram and refcounted_resource_cache_macros.svh.
//
// Usage
//   An item (kind, res_id, slot_in) is taken at a rising edge where start is
//   high and busy is low. Exactly one result follows on o_rsp, valid for the
//   single cycle in which o_strobe is high; the receiver cannot hold it off.
//   An acquire walks the slot table one slot per cycle through the table
//   memory's single read port; a hit ends the walk at its slot, a miss or
//   a full table reads every slot below hw, the high-water mark (none while
//   the table is still empty). A release of a slot below the mark reads it
//   and, unless it is empty, writes it back with its count lowered; one at
//   or above the mark is answered without a table read and busy does not
//   rise for it. Otherwise busy stays high from acceptance until the result
//   cycle, in which the next item may already be taken.
//   Reset clears the high-water mark and the sequencer only; table entries
//   at or above the mark are never read, so the memory needs no clearing pass
//   and the block accepts items from the first cycle after reset.
`default_nettype none
`include "refcounted_resource_cache_macros.svh"

module refcounted_resource_cache #(
    parameter int TABLE_SLOTS = rrc_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire rrc_pkg::t_req i_req,
    output logic             busy,
    output logic             o_strobe,
    output rrc_pkg::t_rsp    o_rsp
);

    import rrc_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int HW_W   = $clog2(TABLE_SLOTS + 1);
    localparam int CW     = (HW_W > SLOT_W8) ? HW_W : SLOT_W8 + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_REL  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [HW_W-1:0]     r_hw, n_hw;
    logic [HW_W-1:0]     r_addr, n_addr;
    logic                r_pend, n_pend;
    logic [SLOT_W-1:0]   r_pend_addr, n_pend_addr;
    logic                r_have_empty, n_have_empty;
    logic [SLOT_W-1:0]   r_empty, n_empty;
    logic [RES_ID_W-1:0] r_id, n_id;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_out_vld, n_out_vld;
    t_rsp                r_rsp, n_rsp;

    logic                mem_we, mem_re;
    logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata, mem_rdata;
    logic [ID_W-1:0]     rd_id;
    logic [CNT_W-1:0]    rd_cnt;
    logic [CNT_W-1:0]    cnt_next;
    logic                hit;

    function automatic logic [SLOT_W8-1:0] to_slot8(input logic [SLOT_W-1:0] idx);
        logic [CW-1:0] wide;
        wide = CW'(idx);
        return wide[SLOT_W8-1:0];
    endfunction

    rrc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_id  = mem_rdata[WORD_W-1:CNT_W];
    assign rd_cnt = mem_rdata[CNT_W-1:0];
    assign hit    = r_pend && (rd_id == {1'b0, r_id});

    always_comb begin
        n_state      = r_state;
        n_hw         = r_hw;
        n_addr       = r_addr;
        n_pend       = r_pend;
        n_pend_addr  = r_pend_addr;
        n_have_empty = r_have_empty;
        n_empty      = r_empty;
        n_id         = r_id;
        n_slot       = r_slot;
        n_out_vld    = 1'b0;
        n_rsp        = r_rsp;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_addr[SLOT_W-1:0];
        cnt_next     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.kind == KIND_ACQUIRE) begin
                        n_id         = i_req.res_id;
                        n_addr       = '0;
                        n_pend       = 1'b0;
                        n_have_empty = 1'b0;
                        n_state      = S_SCAN;
                    end else if (CW'(i_req.slot_in) >= CW'(r_hw)) begin
                        n_out_vld      = 1'b1;
                        n_rsp          = '0;
                        n_rsp.slot_out = i_req.slot_in;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = SLOT_W'(CW'(i_req.slot_in));
                        n_slot    = SLOT_W'(CW'(i_req.slot_in));
                        n_state   = S_REL;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    cnt_next        = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
                    mem_we          = 1'b1;
                    mem_waddr       = r_pend_addr;
                    mem_wdata       = {rd_id, cnt_next};
                    n_out_vld       = 1'b1;
                    n_rsp           = '0;
                    n_rsp.ok        = 1'b1;
                    n_rsp.slot_out  = to_slot8(r_pend_addr);
                    n_rsp.use_count = cnt_next;
                    n_state         = S_IDLE;
                end else begin
                    // The last empty slot seen wins, so later ones overwrite.
                    if (r_pend && (rd_id == EMPTY_ID)) begin
                        n_have_empty = 1'b1;
                        n_empty      = r_pend_addr;
                    end
                    if (r_addr < r_hw) begin
                        mem_re      = 1'b1;
                        mem_raddr   = r_addr[SLOT_W-1:0];
                        n_addr      = r_addr + 1'b1;
                        n_pend      = 1'b1;
                        n_pend_addr = r_addr[SLOT_W-1:0];
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                            n_rsp     = '0;
                            priority if (r_have_empty) begin
                                mem_we           = 1'b1;
                                mem_waddr        = r_empty;
                                mem_wdata        = {1'b0, r_id, CNT_W'(1)};
                                n_rsp.ok         = 1'b1;
                                n_rsp.slot_out   = to_slot8(r_empty);
                                n_rsp.needs_load = 1'b1;
                                n_rsp.use_count  = CNT_W'(1);
                            end else if (r_hw == HW_W'(TABLE_SLOTS)) begin
                                n_rsp.ok = 1'b0;
                            end else begin
                                mem_we           = 1'b1;
                                mem_waddr        = r_hw[SLOT_W-1:0];
                                mem_wdata        = {1'b0, r_id, CNT_W'(1)};
                                n_hw             = r_hw + 1'b1;
                                n_rsp.ok         = 1'b1;
                                n_rsp.slot_out   = to_slot8(r_hw[SLOT_W-1:0]);
                                n_rsp.needs_load = 1'b1;
                                n_rsp.use_count  = CNT_W'(1);
                            end
                        end
                    end
                end
            end

            S_REL: begin
                n_out_vld      = 1'b1;
                n_state        = S_IDLE;
                n_rsp          = '0;
                n_rsp.slot_out = to_slot8(r_slot);
                if (rd_id != EMPTY_ID) begin
                    cnt_next        = rd_cnt - 1'b1;
                    mem_we          = 1'b1;
                    mem_waddr       = r_slot;
                    n_rsp.ok        = 1'b1;
                    n_rsp.use_count = cnt_next;
                    if (cnt_next == '0) begin
                        mem_wdata   = {EMPTY_ID, cnt_next};
                        n_rsp.freed = 1'b1;
                    end else begin
                        mem_wdata = {rd_id, cnt_next};
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hw      <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hw      <= n_hw;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
        r_addr       <= n_addr;
        r_pend_addr  <= n_pend_addr;
        r_have_empty <= n_have_empty;
        r_empty      <= n_empty;
        r_id         <= n_id;
        r_slot       <= n_slot;
        r_rsp        <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_rsp    = r_rsp;

    `RRC_ASSERT_SAME(a_hw_bound, 1'b1, r_hw <= HW_W'(TABLE_SLOTS), "high-water mark beyond table")
    `RRC_ASSERT_SAME(a_hw_step, n_hw != r_hw, mem_we && (n_hw == r_hw + 1'b1), "bad mark step")
    `RRC_ASSERT_SAME(a_strobe_idle, o_strobe, r_state == S_IDLE, "result while busy")
    `RRC_ASSERT_SAME(a_no_write_idle, mem_we, r_state != S_IDLE, "table written with no item at work")

endmodule

`default_nettype wire

/* verif/tb_refcounted_resource_cache.sv */
// Self-checking testbench for refcounted_resource_cache: drives acquire and
// release items, predicts every result and compares it field by field.
// Depends on rrc_pkg and the refcounted_resource_cache RTL.
module tb_refcounted_resource_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import rrc_pkg::*;

    localparam int SLOTS        = TABLE_SLOTS_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int FILL_IDS     = 300;
    localparam int FILL_BASE    = 16'h4000;
    localparam int NO_IDLE_FROM = 300;
    localparam int NO_IDLE_TO   = 560;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req cmd     = '0;
    logic busy;
    logic strobe;
    t_rsp rsp;

    t_req pending_items[$];
    t_rsp awaited_results[$];
    t_rsp due;
    logic gap;

    // Predicted table contents; only entries below mark are ever looked at.
    logic [ID_W-1:0]     slot_ids [SLOTS];
    logic [CNT_W-1:0]    slot_counts [SLOTS];
    int                  mark = 0;
    logic [RES_ID_W-1:0] id_pool [POOL_SIZE];

    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_hits     = 0;
    int n_loads    = 0;
    int n_full     = 0;
    int n_freed    = 0;
    int n_lowered  = 0;
    int n_refused  = 0;

    refcounted_resource_cache uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (cmd),
        .busy    (busy),
        .o_strobe(strobe),
        .o_rsp   (rsp)
    );

    always #5 i_clk = ~i_clk;

    // Applies one item to the predicted table and returns the result it gives.
    function automatic t_rsp cache_step(input t_req req);
        t_rsp r;
        int   k;
        int   found;
        int   vacant;
        int   s;
        r = '0;
        if (req.kind == KIND_ACQUIRE) begin
            found  = -1;
            vacant = -1;
            for (k = 0; k < mark && found < 0; k++) begin
                if (slot_ids[k] == {1'b0, req.res_id}) begin
                    found = k;
                end else if (slot_ids[k] == EMPTY_ID) begin
                    vacant = k;
                end
            end
            if (found >= 0) begin
                if (slot_counts[found] != COUNT_MAX) begin
                    slot_counts[found] = slot_counts[found] + 8'd1;
                end
                r.ok        = 1'b1;
                r.slot_out  = found[SLOT_W8-1:0];
                r.use_count = slot_counts[found];
                n_hits++;
            end else if (vacant < 0 && mark >= SLOTS) begin
                n_full++;
            end else begin
                // The last empty slot seen wins; only without one does the table grow.
                if (vacant < 0) begin
                    vacant = mark;
                    mark++;
                end
                slot_ids[vacant]    = {1'b0, req.res_id};
                slot_counts[vacant] = 8'd1;
                r.ok         = 1'b1;
                r.slot_out   = vacant[SLOT_W8-1:0];
                r.needs_load = 1'b1;
                r.use_count  = 8'd1;
                n_loads++;
            end
        end else begin
            s = int'(req.slot_in);
            r.slot_out = req.slot_in;
            if (s >= mark || slot_ids[s] == EMPTY_ID) begin
                n_refused++;
            end else begin
                slot_counts[s] = slot_counts[s] - 8'd1;
                r.ok = 1'b1;
                if (slot_counts[s] == '0) begin
                    slot_ids[s] = EMPTY_ID;
                    r.freed = 1'b1;
                    n_freed++;
                end else begin
                    r.use_count = slot_counts[s];
                    n_lowered++;
                end
            end
        end
        return r;
    endfunction

    task automatic queue_acquire(input int id);
        t_req r;
        r.kind    = KIND_ACQUIRE;
        r.res_id  = RES_ID_W'(id);
        r.slot_in = SLOT_W8'($urandom_range(255));
        pending_items.push_back(r);
    endtask

    task automatic queue_release(input int slot);
        t_req r;
        r.kind    = KIND_RELEASE;
        r.res_id  = RES_ID_W'($urandom_range(32767));
        r.slot_in = SLOT_W8'(slot);
        pending_items.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40) begin
            $display("%0t ns: result %0d: %s", $time, n_results, msg);
        end
    endtask

    // Driver: an item is taken at an edge where start is high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            cmd   <= '0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(cache_step(cmd));
                n_accepted++;
            end
            if (!start || !busy) begin
                gap = (n_accepted < NO_IDLE_FROM || n_accepted >= NO_IDLE_TO)
                      && ($urandom_range(99) < 25);
                if (pending_items.size() != 0 && !gap) begin
                    start <= 1'b1;
                    cmd   <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe carries one result, taken at the edge ending its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && strobe === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result arrived with nothing outstanding");
            end else begin
                due = awaited_results.pop_front();
                if (rsp.ok !== due.ok) begin
                    report_mismatch($sformatf("ok %b, expected %b", rsp.ok, due.ok));
                end
                if (rsp.slot_out !== due.slot_out) begin
                    report_mismatch($sformatf("slot_out %0d, expected %0d",
                                              rsp.slot_out, due.slot_out));
                end
                if (rsp.needs_load !== due.needs_load) begin
                    report_mismatch($sformatf("needs_load %b, expected %b",
                                              rsp.needs_load, due.needs_load));
                end
                if (rsp.use_count !== due.use_count) begin
                    report_mismatch($sformatf("use_count %0d, expected %0d",
                                              rsp.use_count, due.use_count));
                end
                if (rsp.freed !== due.freed) begin
                    report_mismatch($sformatf("freed %b, expected %b", rsp.freed, due.freed));
                end
            end
            n_results++;
        end
    end

    initial begin
        int k;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) begin
            id_pool[k] = RES_ID_W'($urandom_range(16'h3FFF));
        end

        // Directed: empty table, hit and miss, freeing, reuse of empty slots.
        queue_release(0);
        queue_release(255);
        queue_acquire(0);
        queue_acquire(0);
        queue_acquire(16'h7FFF);
        queue_acquire(16'h5555);
        queue_acquire(16'h2AAA);
        queue_release(1);
        queue_release(1);
        queue_release(2);
        queue_acquire(16'h1234);
        queue_acquire(16'h7FFF);
        queue_release(4);
        queue_release(0);
        queue_acquire(16'h5555);
        queue_release(3);

        // Drive one count into saturation, then back off it.
        for (k = 0; k < 258; k++) begin
            queue_acquire(0);
        end
        queue_release(0);
        queue_release(0);

        // Small table: a pool of ids with frequent releases.
        for (k = 0; k < 350; k++) begin
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(9) == 0) begin
                    queue_acquire($urandom_range(32767));
                end else begin
                    queue_acquire(id_pool[$urandom_range(POOL_SIZE - 1)]);
                end
            end else if ($urandom_range(9) == 0) begin
                queue_release($urandom_range(255));
            end else begin
                queue_release($urandom_range(31));
            end
        end

        // More distinct ids than there are slots: the table fills and then refuses.
        for (k = 0; k < FILL_IDS; k++) begin
            queue_acquire(FILL_BASE + k);
        end

        // Full table: releases open holes that later misses take over.
        for (k = 0; k < 300; k++) begin
            if ($urandom_range(99) < 50) begin
                queue_release($urandom_range(255));
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3: queue_acquire(FILL_BASE + $urandom_range(FILL_IDS - 1));
                    4, 5, 6:    queue_acquire(id_pool[$urandom_range(POOL_SIZE - 1)]);
                    default:    queue_acquire($urandom_range(32767));
                endcase
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d results: %0d acquire hits, %0d loads, %0d refused on a full table.",
                 n_results, n_hits, n_loads, n_full);
        $display("Releases: %0d emptied a slot, %0d lowered a count, %0d refused; %0d mismatches.",
                 n_freed, n_lowered, n_refused, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run takes a few milliseconds at most.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/rrc_pkg.sv
src/rrc_ram.sv
src/refcounted_resource_cache.sv
verif/tb_refcounted_resource_cache.sv
